/* hw/rtl/b64d_pkg.sv */
// shared types, constants and the alphabet lookup for the base64 decoder
// no dependencies
`default_nettype none

package b64d_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_PAD = 8'h3D; // '='

	// up to three bytes produced by one input character
	typedef struct packed {
		logic [1:0]      cnt;   // 1..3
		logic            ends;  // character ended the message
		logic [2:0][7:0] bytes; // bytes[0] goes out first
	} job_t;

	// sextet lookup result
	typedef struct packed {
		logic       hit;
		logic [5:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t    r;
		logic [7:0] d;
		r = '0;
		d = '0;
		if (c >= "A" && c <= "Q") begin
			d = c - "A";
			r = '{hit: 1'b1, val: d[5:0]};
		end else if (c == "!") begin
			r = '{hit: 1'b1, val: 6'd17};
		end else if (c == "@") begin
			r = '{hit: 1'b1, val: 6'd18};
		end else if (c == "#") begin
			r = '{hit: 1'b1, val: 6'd19};
		end else if (c == "$") begin
			r = '{hit: 1'b1, val: 6'd20};
		end else if (c == "%") begin
			r = '{hit: 1'b1, val: 6'd21};
		end else if (c >= "W" && c <= "Z") begin
			d = c - "W" + 8'd22;
			r = '{hit: 1'b1, val: d[5:0]};
		end else if (c >= "a" && c <= "z") begin
			d = c - "a" + 8'd26;
			r = '{hit: 1'b1, val: d[5:0]};
		end else if (c >= "0" && c <= "9") begin
			d = c - "0" + 8'd52;
			r = '{hit: 1'b1, val: d[5:0]};
		end else if (c == "+") begin
			r = '{hit: 1'b1, val: 6'd62};
		end else if (c == "/") begin
			r = '{hit: 1'b1, val: 6'd63};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64d_front.sv */
// front end: classifies characters, holds the group of sextets and builds byte jobs
// depends on b64d_pkg
`default_nettype none

module b64d_front
	import b64d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,        // a character is accepted this cycle
	input  wire logic [7:0] char_in,
	input  wire logic       end_of_text,
	output logic            push,
	output job_t            job
);

	logic [1:0]      phase_q;
	logic [2:0][5:0] sx_q;
	logic            pad_q;
	sextet_t         sx;
	logic [7:0]      b0, b1, b2;

	assign sx = sextet_of(char_in);
	assign b0 = {sx_q[0], sx_q[1][5:4]};
	assign b1 = {sx_q[1][3:0], sx_q[2][5:2]};
	assign b2 = {sx_q[2][1:0], sx.val};

	always_comb begin
		push      = 1'b0;
		job.cnt   = 2'd0;
		job.ends  = end_of_text;
		job.bytes = {b2, b1, b0};
		if (take && !pad_q) begin
			if (char_in == CH_PAD) begin
				job.ends = 1'b1;
				if (phase_q >= 2'd2) begin
					push    = 1'b1;
					job.cnt = (phase_q == 2'd3) ? 2'd2 : 2'd1;
				end
			end else if (sx.hit && phase_q == 2'd3) begin
				push    = 1'b1;
				job.cnt = 2'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			sx_q    <= '0;
			pad_q   <= 1'b0;
		end else if (take) begin
			if (end_of_text) begin
				phase_q <= '0;
				sx_q    <= '0;
				pad_q   <= 1'b0;
			end else if (!pad_q) begin
				if (char_in == CH_PAD) begin
					pad_q <= 1'b1;
				end else if (sx.hit) begin
					if (phase_q == 2'd3) begin
						phase_q <= '0;
						sx_q    <= '0;
					end else begin
						sx_q[phase_q] <= sx.val;
						phase_q       <= phase_q + 2'd1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/b64d_fifo.sv */
// short job queue between the front end and the byte emitter
// depends on b64d_pkg
`default_nettype none

module b64d_fifo
	import b64d_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	input  wire logic pop,
	output job_t      rd_job,
	output logic      full,
	output logic      empty
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QDEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/b64d_back.sv */
// back end: walks the bytes of the head job into the output register
// depends on b64d_pkg
`default_nettype none

module b64d_back
	import b64d_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire job_t  head,
	input  wire logic  head_valid,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [7:0] byte_out,
	output logic       last_of_run,
	output logic       message_done
);

	logic [1:0] k_q;
	logic       load;
	logic       last;
	logic [7:0] sel;

	assign load = head_valid && (!out_valid || out_ready);
	assign last = (k_q == head.cnt - 2'd1);
	assign pop  = load && last;

	always_comb begin
		case (k_q)
			2'd0:    sel = head.bytes[0];
			2'd1:    sel = head.bytes[1];
			2'd2:    sel = head.bytes[2];
			default: sel = head.bytes[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				k_q       <= last ? 2'd0 : k_q + 2'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_out     <= sel;
			last_of_run  <= last;
			message_done <= last && head.ends;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/base64_custom_alphabet_decoder_core.sv */
// base64 decoder with a custom alphabet: one character in per cycle unless the queue is full,
// bytes out one per cycle while out_ready is high; a job is written into the job queue, then
// its bytes pass into the output register; a full group leaves as three bytes,
// buffered by a four-entry job queue between the front end and the output register
// reset: arst_n clears group state, padding flag, queue pointers and output valid
// depends on b64d_pkg, b64d_front, b64d_fifo, b64d_back
`default_nettype none

module base64_custom_alphabet_decoder_core
	import b64d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_in,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      byte_out,
	output logic            last_of_run,
	output logic            message_done
);

	logic push, pop, full, empty, take;
	job_t wr_job, rd_job;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.char_in     (char_in),
		.end_of_text (end_of_text),
		.push        (push),
		.job         (wr_job)
	);

	b64d_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.full   (full),
		.empty  (empty)
	);

	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (rd_job),
		.head_valid   (!empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_out     (byte_out),
		.last_of_run  (last_of_run),
		.message_done (message_done)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("job popped from empty queue");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> last_of_run)
		else $error("message end on a byte that is not last of its run");

	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> wr_job.cnt != 2'd0) else $error("empty job queued");

endmodule

`default_nettype wire
